### rtl/m127_pkg.sv
// Shared types and constants for the modulo 2^127-1 field ALU.
package m127_pkg;

    localparam int FW    = 127;             // field element width
    localparam int EXP_W = 64;              // pow exponent width
    localparam int CNT_W = $clog2(FW);      // multiplier bit counter
    localparam int IN_W  = 328;             // 321 payload bits, byte padded
    localparam int OUT_W = 136;             // 129 payload bits, byte padded

    localparam logic [FW-1:0] PRIME      = {FW{1'b1}};
    localparam logic [FW-1:0] PRIME_M2   = {{(FW-2){1'b1}}, 2'b01};
    localparam logic [FW-1:0] SCALED_ONE = FW'(2);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_POW = 3'd3,
        OP_INV = 3'd4,
        OP_C2S = 3'd5,
        OP_S2C = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_OPND = 2'd1,
        STS_INV_ZERO = 2'd2
    } sts_t;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_EXP  = 2'd1,
        SQ_MUL  = 2'd2,
        SQ_DONE = 2'd3
    } seq_state_t;

    // where a finished product goes
    typedef enum logic [1:0] {
        MK_RES  = 2'd0,
        MK_R    = 2'd1,
        MK_BASE = 2'd2
    } mul_kind_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [FW-1:0]    a;
        logic [FW-1:0]    b;
        logic [EXP_W-1:0] e;
    } req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    function automatic logic [FW-1:0] rotl1(input logic [FW-1:0] v);
        return {v[FW-2:0], v[FW-1]};
    endfunction

    function automatic logic [FW-1:0] rotr1(input logic [FW-1:0] v);
        return {v[0], v[FW-1:1]};
    endfunction

endpackage

### rtl/m127_modadd.sv
// Modular adder for p = 2^127-1 (end-around carry, p folded to zero).
module m127_modadd (
    input  logic [m127_pkg::FW-1:0] x,
    input  logic [m127_pkg::FW-1:0] y,
    output logic [m127_pkg::FW-1:0] sum
);
    import m127_pkg::*;

    logic [FW:0]   raw;
    logic [FW-1:0] fold;

    // y may equal p (negated zero); x + p still folds back to x
    always_comb begin
        raw  = {1'b0, x} + {1'b0, y};
        fold = raw[FW-1:0] + FW'(raw[FW]);
        sum  = (fold == PRIME) ? '0 : fold;
    end

endmodule

### rtl/m127_seq.sv
// Sequencer: operand checks, bit-serial modular multiply, square-and-multiply.
module m127_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  m127_pkg::req_t          req,
    input  logic                    take,
    output m127_pkg::seq_stat_t     stat,
    output logic [m127_pkg::FW-1:0] res,
    output logic [1:0]              status
);
    import m127_pkg::*;

    seq_state_t       state_reg, state_next;
    mul_kind_t        kind_reg, kind_next;
    logic [FW-1:0]    acc_reg, acc_next;
    logic [FW-1:0]    mx_reg, mx_next;
    logic [FW-1:0]    my_reg, my_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [FW-1:0]    r_reg, r_next;
    logic [FW-1:0]    base_reg, base_next;
    logic [FW-1:0]    e_reg, e_next;
    logic [FW-1:0]    res_reg, res_next;
    logic [1:0]       sts_reg, sts_next;

    logic [FW-1:0] add_x, add_y, add_s, prod;
    logic          uses_b;

    m127_modadd u_add (
        .x   (add_x),
        .y   (add_y),
        .sum (add_s)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        acc_reg  <= acc_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        cnt_reg  <= cnt_next;
        r_reg    <= r_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
        sts_reg  <= sts_next;
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        base_next  = base_reg;
        e_next     = e_reg;
        res_next   = res_reg;
        sts_next   = sts_reg;

        // multiply step: acc = 2*acc + bit*x, MSB of multiplier first
        add_x = rotl1(acc_reg);
        add_y = my_reg[FW-1] ? mx_reg : '0;
        prod  = rotr1(add_s);   // final halving
        uses_b = (req.op == OP_ADD) || (req.op == OP_SUB) || (req.op == OP_MUL);

        if (state_reg == SQ_IDLE) begin
            add_x = req.a;
            add_y = (req.op == OP_SUB) ? ~req.b :
                    (req.op == OP_C2S) ? req.a : req.b;
        end

        unique case (state_reg)
            SQ_IDLE: begin
                if (start) begin
                    res_next   = '0;
                    sts_next   = STS_OK;
                    state_next = SQ_DONE;
                    if (req.a == PRIME || (uses_b && req.b == PRIME)) begin
                        if (req.op <= OP_S2C) begin
                            sts_next = STS_BAD_OPND;
                        end
                    end else begin
                        unique case (req.op)
                            OP_ADD, OP_SUB, OP_C2S: res_next = add_s;
                            OP_S2C: res_next = rotr1(req.a);
                            OP_MUL: begin
                                mx_next    = req.a;
                                my_next    = req.b;
                                acc_next   = '0;
                                cnt_next   = '0;
                                kind_next  = MK_RES;
                                state_next = SQ_MUL;
                            end
                            OP_POW: begin
                                r_next     = SCALED_ONE;
                                base_next  = req.a;
                                e_next     = FW'(req.e);
                                state_next = SQ_EXP;
                            end
                            OP_INV: begin
                                if (req.a == '0) begin
                                    sts_next = STS_INV_ZERO;
                                end else begin
                                    r_next     = SCALED_ONE;
                                    base_next  = req.a;
                                    e_next     = PRIME_M2;
                                    state_next = SQ_EXP;
                                end
                            end
                            default: ;  // reserved code: zero result, ok
                        endcase
                    end
                end
            end
            SQ_EXP: begin
                acc_next = '0;
                cnt_next = '0;
                if (e_reg == '0) begin
                    res_next   = r_reg;
                    state_next = SQ_DONE;
                end else if (e_reg[0]) begin
                    mx_next    = base_reg;
                    my_next    = r_reg;
                    kind_next  = MK_R;
                    state_next = SQ_MUL;
                end else begin
                    e_next = e_reg >> 1;
                    // square only while exponent bits remain
                    if (e_reg[FW-1:1] != '0) begin
                        mx_next    = base_reg;
                        my_next    = base_reg;
                        kind_next  = MK_BASE;
                        state_next = SQ_MUL;
                    end
                end
            end
            SQ_MUL: begin
                acc_next = add_s;
                my_next  = my_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FW - 1)) begin
                    unique case (kind_reg)
                        MK_RES: begin
                            res_next   = prod;
                            state_next = SQ_DONE;
                        end
                        MK_R: begin
                            r_next     = prod;
                            e_next     = {e_reg[FW-1:1], 1'b0};
                            state_next = SQ_EXP;
                        end
                        MK_BASE: begin
                            base_next  = prod;
                            state_next = SQ_EXP;
                        end
                        default: state_next = SQ_EXP;
                    endcase
                end
            end
            SQ_DONE: begin
                if (take) begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    assign stat.idle = (state_reg == SQ_IDLE);
    assign stat.done = (state_reg == SQ_DONE);
    assign res       = res_reg;
    assign status    = sts_reg;

endmodule

### rtl/mersenne127_field_alu_unit.sv
// Top level of the field ALU modulo 2^127-1 with stream request and result ports.
//
// One request in, one result out. s_tdata carries the operation and operands;
// m_tdata carries the 127-bit result and a status code. Values are in the
// scaled form 2v mod p; mul returns a*b/2 mod p.
// Work per request until the result can be taken (m_tvalid high):
//   add, sub, conversions, any error, reserved op : no multiplier pass
//   mul : 127 steps of the shared modular adder, 1 bit each
//   pow : a series of multiplies and squarings, by exponent bit
//   inv : 252 multiplications
// The throughput limit is the single modular adder inside the bit-serial
// multiplier; one request is worked on at a time and s_tready is low while
// the sequencer is busy.
// A finished result sits in the output register; a new request is taken
// while it waits. If the receiver stalls and a second result completes, the
// sequencer holds it and keeps s_tready low until the register frees up.
// Reset (aresetn low, synchronous) empties the output register and returns
// the sequencer to idle.
module mersenne127_field_alu_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // req_type[2:0], a_lo[66:3], a_hi[129:67], b_lo[193:130], b_hi[256:194],
    // exponent[320:257], zero pad
    input  logic [m127_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // result_lo[63:0], result_hi[126:64], status[128:127], zero pad
    output logic [m127_pkg::OUT_W-1:0] m_tdata
);
    import m127_pkg::*;

    req_t                req;
    seq_stat_t           stat;
    logic [FW-1:0]       res;
    logic [1:0]          status;
    logic                take;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    // unpack the request
    assign req.op = s_tdata[2:0];
    assign req.a  = {s_tdata[129:67], s_tdata[66:3]};
    assign req.b  = {s_tdata[256:194], s_tdata[193:130]};
    assign req.e  = s_tdata[320:257];

    // output register free, or being emptied this cycle
    assign take = !m_tvalid_reg || m_tready;

    m127_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_tvalid && stat.idle),
        .req     (req),
        .take    (take),
        .stat    (stat),
        .res     (res),
        .status  (status)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (stat.done && take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {(OUT_W - FW - 2)'(0), status, res};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = stat.idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/m127_checker.sv
// Port-level checks for the field ALU, bound to the top level.
module m127_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [m127_pkg::OUT_W-1:0] m_tdata
);
    import m127_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[FW+1:FW] != STS_OK |-> m_tdata[FW-1:0] == '0)
        else $error("error result not zero");

    // one request at a time: busy straight after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // values are always reduced below p and the status code is a defined one
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[FW-1:0] != PRIME && m_tdata[FW+1:FW] <= STS_INV_ZERO)
        else $error("unreduced result or bad status");

endmodule

bind mersenne127_field_alu_unit m127_checker u_m127_checker (.*);

### bench/m127_alu_checker.sv
// Result checker for the modulo 2^127-1 field ALU: predicts each answer and compares.
module m127_alu_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [m127_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [m127_pkg::OUT_W-1:0] m_tdata,
    output int                         mismatches,
    output int                         awaiting
);
    import m127_pkg::*;

    typedef logic [FW-1:0] felem_t;

    typedef struct packed {
        felem_t value;
        sts_t   sts;
    } answer_t;

    answer_t answers_due[$];
    answer_t want;
    int      err_tally;
    logic [63:0] got_lo;
    logic [62:0] got_hi;
    logic [1:0]  got_sts;

    function automatic felem_t field_add(input felem_t x, input felem_t y);
        logic [FW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, PRIME}) begin
            s = s - {1'b0, PRIME};
        end
        return s[FW-1:0];
    endfunction

    function automatic felem_t field_sub(input felem_t x, input felem_t y);
        if (x >= y) begin
            return x - y;
        end
        return PRIME - (y - x);
    endfunction

    function automatic felem_t field_halve(input felem_t x);
        logic [FW:0] t;
        t = {1'b0, x};
        if (x[0]) begin
            t = t + {1'b0, PRIME};
        end
        return t[FW:1];
    endfunction

    // x*y/2 mod p, msb-first double-and-add
    function automatic felem_t field_mul_scaled(input felem_t x, input felem_t y);
        felem_t acc;
        acc = '0;
        for (int i = FW - 1; i >= 0; i--) begin
            acc = field_add(acc, acc);
            if (y[i]) begin
                acc = field_add(acc, x);
            end
        end
        return field_halve(acc);
    endfunction

    function automatic felem_t field_pow(input felem_t base, input felem_t ex);
        felem_t acc;
        acc = SCALED_ONE;
        while (ex != '0) begin
            if (ex[0]) begin
                acc = field_mul_scaled(acc, base);
            end
            ex = ex >> 1;
            if (ex != '0) begin
                base = field_mul_scaled(base, base);
            end
        end
        return acc;
    endfunction

    function automatic answer_t alu_outcome(input logic [2:0] op, input felem_t a,
                                            input felem_t b, input logic [EXP_W-1:0] e);
        answer_t ans;
        logic    uses_b;
        ans.value = '0;
        ans.sts   = STS_OK;
        uses_b = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL);
        // reserved code skips the operand range check altogether
        if (op <= OP_S2C && (a == PRIME || (uses_b && b == PRIME))) begin
            ans.sts = STS_BAD_OPND;
        end else begin
            case (op)
                OP_ADD: ans.value = field_add(a, b);
                OP_SUB: ans.value = field_sub(a, b);
                OP_MUL: ans.value = field_mul_scaled(a, b);
                OP_POW: ans.value = field_pow(a, felem_t'(e));
                OP_INV: begin
                    if (a == '0) begin
                        ans.sts = STS_INV_ZERO;
                    end else begin
                        ans.value = field_pow(a, PRIME_M2);
                    end
                end
                OP_C2S: ans.value = field_add(a, a);
                OP_S2C: ans.value = field_halve(a);
                default: ;
            endcase
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                answers_due.insert(answers_due.size(),
                                   alu_outcome(s_tdata[2:0], s_tdata[129:3],
                                               s_tdata[256:130], s_tdata[320:257]));
            end
            if (m_tvalid && m_tready) begin
                got_lo  = m_tdata[63:0];
                got_hi  = m_tdata[126:64];
                got_sts = m_tdata[128:127];
                if (answers_due.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    err_tally++;
                end else begin
                    want = answers_due.pop_front();
                    if (got_lo !== want.value[63:0]) begin
                        $error("result_lo: expected %h, got %h", want.value[63:0], got_lo);
                        err_tally++;
                    end
                    if (got_hi !== want.value[126:64]) begin
                        $error("result_hi: expected %h, got %h", want.value[126:64], got_hi);
                        err_tally++;
                    end
                    if (got_sts !== want.sts) begin
                        $error("status: expected %0d, got %0d", want.sts, got_sts);
                        err_tally++;
                    end
                end
            end
            mismatches <= err_tally;
            awaiting   <= answers_due.size();
        end
    end

endmodule

### bench/tb.sv
// Testbench top for the modulo 2^127-1 field ALU: request stimulus, result stalls, verdict.
module tb;
    import m127_pkg::*;

    typedef logic [FW-1:0] felem_t;

    // reserved request code, not in op_t; the unit must answer it with all zeros
    localparam logic [2:0] OP_RESERVED = 3'd7;
    localparam felem_t     P_MINUS_1   = PRIME - 1'b1;
    // the run time is dominated by inv and long pow
    localparam int         CYCLE_LIMIT = 6_000_000;
    // leave a margin after the last result for stray results
    localparam int         TAIL_CYCLES = 40;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               mismatches;
    int               awaiting;
    int               cycle_count;
    bit               tx_calm;

    mersenne127_field_alu_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    m127_alu_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // watchdog: a hung unit or a lost result ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Operand mix: field extremes, p itself (bad operand), small and random values.
    function automatic felem_t pick_operand();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return felem_t'(1);
            2:       return PRIME;
            3:       return P_MINUS_1;
            4:       return PRIME - felem_t'($urandom_range(1, 64));
            5:       return felem_t'($urandom_range(0, 255));
            6:       return SCALED_ONE;
            default: return raw[FW-1:0];
        endcase
    endfunction

    // One request: random idle gap, then hold tvalid until the unit takes it.
    // Inputs move on the falling edge only.
    task automatic issue_request(input logic [2:0] op, input felem_t a, input felem_t b,
                                 input logic [EXP_W-1:0] e);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({e, b, a, op});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and hold off until every outstanding request has been answered.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
    endtask

    // Result side: random stall before each result, with calm stretches of no stalling.
    initial begin
        int stall;
        bit rx_calm;
        m_tready = 1'b0;
        rx_calm  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                rx_calm = !rx_calm;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Request stimulus and verdict.
    initial begin
        int          pick;
        logic [2:0]  op;
        felem_t      a;
        felem_t      b;
        logic [63:0] e;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        tx_calm  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed requests ----
        // add: zeros, wrap past p, bad first operand
        issue_request(OP_ADD, '0, '0, '0);
        issue_request(OP_ADD, P_MINUS_1, P_MINUS_1, '1);
        issue_request(OP_ADD, PRIME, felem_t'(5), '0);
        // sub: borrow round p, bad second operand
        issue_request(OP_SUB, '0, felem_t'(1), '0);
        issue_request(OP_SUB, felem_t'(9), PRIME, '0);
        // mul: largest operands, scaled one times x, zero operand
        issue_request(OP_MUL, P_MINUS_1, P_MINUS_1, '0);
        issue_request(OP_MUL, SCALED_ONE, pick_operand(), '1);
        issue_request(OP_MUL, '0, P_MINUS_1, '0);
        // pow: zero exponent gives the scaled one, full exponent, zero base, bad base
        issue_request(OP_POW, P_MINUS_1, '0, '0);
        issue_request(OP_POW, felem_t'(3), PRIME, '1);
        issue_request(OP_POW, '0, '0, 64'd5);
        issue_request(OP_POW, PRIME, '0, {$urandom, $urandom});
        // inv: of zero, of p (bad operand wins), of the scaled one, of p-1
        issue_request(OP_INV, '0, '1, '0);
        issue_request(OP_INV, PRIME, '0, '0);
        issue_request(OP_INV, SCALED_ONE, PRIME, '0);
        issue_request(OP_INV, P_MINUS_1, '0, '1);
        // conversions; b = p must be ignored since these do not use b
        issue_request(OP_C2S, P_MINUS_1, PRIME, '0);
        issue_request(OP_C2S, PRIME, '0, '0);
        issue_request(OP_S2C, felem_t'(1), PRIME, '0);
        issue_request(OP_S2C, P_MINUS_1, '0, '0);
        issue_request(OP_S2C, '0, '0, '1);
        // reserved code with p in both operands: still all zeros, no status
        issue_request(OP_RESERVED, PRIME, PRIME, '1);
        issue_request(OP_RESERVED, pick_operand(), pick_operand(), {$urandom, $urandom});

        // ---- random requests ----
        for (int n = 0; n < 1030; n++) begin
            if (n % 50 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            // once mid-run, starve the unit until it has answered everything
            if (n == 500) begin
                wait_for_results();
            end
            pick = $urandom_range(0, 999);
            if (pick < 220) begin
                op = OP_ADD;
            end else if (pick < 440) begin
                op = OP_SUB;
            end else if (pick < 580) begin
                op = OP_MUL;
            end else if (pick < 650) begin
                op = OP_POW;
            end else if (pick < 660) begin
                // inv is the slowest request, so keep it rare
                op = OP_INV;
            end else if (pick < 790) begin
                op = OP_C2S;
            end else if (pick < 985) begin
                op = OP_S2C;
            end else begin
                op = OP_RESERVED;
            end
            a = pick_operand();
            b = pick_operand();
            e = {$urandom, $urandom};
            // most pow requests get short exponents; a full 64-bit one now and then
            if (op == OP_POW && $urandom_range(0, 7) != 0) begin
                e = 64'($urandom_range(0, 31));
            end
            issue_request(op, a, b, e);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/m127_pkg.sv
rtl/m127_modadd.sv
rtl/m127_seq.sv
rtl/mersenne127_field_alu_unit.sv
rtl/m127_checker.sv
bench/m127_alu_checker.sv
bench/tb.sv
